// ===== rtl/tsb_pkg.sv =====
// Package for the bilinear texture sampler: payload structs, register codes,
// controller/datapath command and status types, lerp functions. No dependencies.
`default_nettype none
package tsb_pkg;
    localparam int DefMaxDim = 256;
    localparam int DefTexelDepth = 65536;

    localparam logic [2:0] REG_FILTER = 3'd0;
    localparam logic [2:0] REG_WRAP_U = 3'd1;
    localparam logic [2:0] REG_WRAP_V = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] texel_index;
        logic [31:0] texel_rgba;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       coord;
        logic       read_en;
        logic [1:0] corner;
        logic       capture;
        logic       vlerp;
        logic       hlerp;
        logic       nearest;
    } dp_cmd_t;

    typedef struct packed {
        logic bilinear;
    } dp_stat_t;

    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [16:0] f);
        logic [25:0] s;
        begin
            s = 26'(a) * 26'(17'h10000 - f) + 26'(b) * 26'(f) + 26'h8000;
            lerp8 = s[23:16];
        end
    endfunction

    function automatic logic [31:0] lerp_texel(input logic [31:0] a, input logic [31:0] b,
                                               input logic [16:0] f);
        logic [31:0] r;
        begin
            for (int i = 0; i < 4; i++) begin
                r[i*8 +: 8] = lerp8(a[i*8 +: 8], b[i*8 +: 8], f);
            end
            lerp_texel = r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/texture_sampler_bilinear.sv =====
// Top level of the texture sampler: APB registers, handshakes, output
// register. Depends on tsb_pkg, tsb_ctrl and tsb_datapath.
// A texel write is stored as the item is taken. A sample runs address, corner
// read, lerp and output steps in turn; the texel memory serves the four
// bilinear corner reads one per cycle, and a nearest sample reads one. The
// result register frees the controller as soon as it is loaded.
`default_nettype none
module texture_sampler_bilinear
    import tsb_pkg::*;
#(
    parameter int MAX_DIM = DefMaxDim,
    parameter int TEXEL_DEPTH = DefTexelDepth
)(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic filter_reg, wrap_u_reg, wrap_v_reg;
    logic [8:0] width_reg, height_reg;
    logic m_valid_reg;
    out_item_t m_data_reg;
    logic busy, res_load, in_fire;
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic [31:0] texel;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= 1'b0;
            wrap_u_reg <= 1'b0;
            wrap_v_reg <= 1'b0;
            width_reg <= 9'd1;
            height_reg <= 9'd1;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                REG_FILTER: filter_reg <= pwdata[0];
                REG_WRAP_U: wrap_u_reg <= pwdata[0];
                REG_WRAP_V: wrap_v_reg <= pwdata[0];
                REG_WIDTH:  width_reg <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_FILTER: prdata = {31'd0, filter_reg};
            REG_WRAP_U: prdata = {31'd0, wrap_u_reg};
            REG_WRAP_V: prdata = {31'd0, wrap_v_reg};
            REG_WIDTH:  prdata = {23'd0, width_reg};
            REG_HEIGHT: prdata = {23'd0, height_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign s_ready = !busy;
    assign in_fire = s_valid && s_ready;

    tsb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .in_sample(s_data.kind == KIND_SAMPLE),
        .out_free(!m_valid_reg || m_ready), .stat(stat),
        .busy(busy), .res_load(res_load), .cmd(cmd)
    );

    tsb_datapath #(.MAX_DIM(MAX_DIM), .TEXEL_DEPTH(TEXEL_DEPTH)) u_dp (
        .aclk(aclk), .item(s_data), .cmd(cmd), .filter_mode(filter_reg),
        .wrap_u(wrap_u_reg), .wrap_v(wrap_v_reg), .tex_width(width_reg),
        .tex_height(height_reg), .stat(stat), .texel(texel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_load) begin
            m_data_reg.red <= texel[7:0];
            m_data_reg.green <= texel[15:8];
            m_data_reg.blue <= texel[23:16];
            m_data_reg.alpha <= texel[31:24];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> m_valid)
        else $error("loaded result not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_data.kind == KIND_SAMPLE) |=> !s_ready)
        else $error("new item taken during sample");
endmodule
`default_nettype wire

// ===== rtl/tsb_ctrl.sv =====
// Sequencing controller for the texture sampler. Uses tsb_pkg for the
// command and status structs.
`default_nettype none
module tsb_ctrl
    import tsb_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_fire,
    input  wire logic     in_sample,
    input  wire logic     out_free,
    input  wire dp_stat_t stat,
    output logic          busy,
    output logic          res_load,
    output dp_cmd_t       cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_COORD = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_LAST  = 3'd3;
    localparam logic [2:0] ST_HLERP = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] corner_reg, corner_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            corner_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            corner_reg <= corner_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        corner_next = corner_reg;
        cmd = '0;
        res_load = 1'b0;
        cmd.corner = corner_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = in_fire;
                if (in_fire && in_sample) begin
                    state_next = ST_COORD;
                end
            end
            ST_COORD: begin
                cmd.coord = 1'b1;
                corner_next = 2'd0;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read_en = 1'b1;
                cmd.capture = (corner_reg != 2'd0);
                if (!stat.bilinear || corner_reg == 2'd3) begin
                    state_next = ST_LAST;
                end
                corner_next = corner_reg + 2'd1;
            end
            ST_LAST: begin
                cmd.nearest = !stat.bilinear;
                cmd.vlerp = stat.bilinear;
                state_next = stat.bilinear ? ST_HLERP : ST_DONE;
            end
            ST_HLERP: begin
                cmd.hlerp = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    res_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        busy = (state_reg != ST_IDLE);
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && in_fire && in_sample) |=> state_reg == ST_COORD)
        else $error("sample not started");
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> state_reg == ST_IDLE)
        else $error("result load left controller busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && !stat.bilinear) |=> state_reg == ST_LAST)
        else $error("nearest sample read more than one texel");
endmodule
`default_nettype wire

// ===== rtl/tsb_datapath.sv =====
// Datapath for the texture sampler: coordinate wrap, texel address
// generation, texel memory and lerp units. Uses tsb_pkg.
`default_nettype none
module tsb_datapath
    import tsb_pkg::*;
#(
    parameter int MAX_DIM = DefMaxDim,
    parameter int TEXEL_DEPTH = DefTexelDepth
)(
    input  wire logic      aclk,
    input  wire in_item_t  item,
    input  wire dp_cmd_t   cmd,
    input  wire logic      filter_mode,
    input  wire logic      wrap_u,
    input  wire logic      wrap_v,
    input  wire logic [8:0] tex_width,
    input  wire logic [8:0] tex_height,
    output dp_stat_t       stat,
    output logic [31:0]    texel
);
    localparam int AW = $clog2(TEXEL_DEPTH);
    localparam int DW = $clog2(MAX_DIM + 1);

    logic [31:0] mem [TEXEL_DEPTH];
    logic [31:0] rd_reg;
    logic [31:0] c0_reg, c1_reg, c2_reg, lc_reg, texel_reg;
    logic [31:0] cu_reg, cv_reg;
    logic        bil_reg;
    logic [16:0] tu, tv, fx_reg, fy_reg;
    logic [DW-1:0] w_eff, h_eff;
    logic [DW+16:0] px, py;
    logic [DW:0] left_reg, right_reg, bot_reg, top_reg;
    logic [DW:0] row, col;
    logic [2*DW+1:0] addr;
    logic        addr_ok, ok_reg;

    function automatic logic [16:0] wrap(input logic [31:0] r, input logic mode);
        begin
            if (!r[31] && r <= 32'h10000) wrap = r[16:0];
            else if (mode) wrap = 17'h10000 - {1'b0, r[15:0]};
            else wrap = {1'b0, r[15:0]};
        end
    endfunction

    function automatic logic [DW-1:0] eff(input logic [8:0] s);
        begin
            if (s == 9'd0) eff = DW'(1);
            else if (32'(s) > MAX_DIM) eff = DW'(MAX_DIM);
            else eff = DW'(s);
        end
    endfunction

    always_comb begin
        w_eff = eff(tex_width);
        h_eff = eff(tex_height);
        tu = wrap(cu_reg, wrap_u);
        tv = wrap(cv_reg, wrap_v);
        px = (DW+17)'(tu) * (DW+17)'(w_eff - DW'(1));
        py = (DW+17)'(tv) * (DW+17)'(h_eff - DW'(1));
        row = cmd.corner[0] ? top_reg : bot_reg;
        col = cmd.corner[1] ? right_reg : left_reg;
        addr = (2*DW+2)'(row) * (2*DW+2)'(w_eff) + (2*DW+2)'(col);
        addr_ok = (32'(addr) < TEXEL_DEPTH);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cu_reg <= item.coord_u;
            cv_reg <= item.coord_v;
            bil_reg <= filter_mode;
            if (item.kind == KIND_WRITE && 32'(item.texel_index) < TEXEL_DEPTH) begin
                mem[AW'(item.texel_index)] <= item.texel_rgba;
            end
        end
        if (cmd.coord) begin
            fx_reg <= {1'b0, px[15:0]};
            fy_reg <= {1'b0, py[15:0]};
            if (bil_reg) begin
                left_reg <= (DW+1)'(px >> 16);
                bot_reg <= (DW+1)'(py >> 16);
                right_reg <= (DW+1)'(px >> 16) + (DW+1)'(px[15:0] != 16'd0);
                top_reg <= (DW+1)'(py >> 16) + (DW+1)'(py[15:0] != 16'd0);
            end else begin
                left_reg <= (DW+1)'((px + (DW+17)'(17'h8000)) >> 16);
                bot_reg <= (DW+1)'((py + (DW+17)'(17'h8000)) >> 16);
            end
        end
        if (cmd.read_en) begin
            rd_reg <= mem[AW'(addr)];
            ok_reg <= addr_ok;
        end
        if (cmd.capture) begin
            c2_reg <= c1_reg;
            c1_reg <= c0_reg;
            c0_reg <= ok_reg ? rd_reg : 32'd0;
        end
        if (cmd.vlerp) begin
            lc_reg <= lerp_texel(c2_reg, c1_reg, fy_reg);
            c1_reg <= lerp_texel(c0_reg, ok_reg ? rd_reg : 32'd0, fy_reg);
        end
        if (cmd.nearest) texel_reg <= ok_reg ? rd_reg : 32'd0;
        if (cmd.hlerp) texel_reg <= lerp_texel(lc_reg, c1_reg, fx_reg);
    end

    assign stat.bilinear = bil_reg;
    assign texel = texel_reg;
endmodule
`default_nettype wire

// ===== dv/texture_sampler_checker.sv =====
// Checker for the texture sampler: watches the APB port and both channels,
// predicts each sampled color and compares it. Depends on tsb_pkg.
module texture_sampler_checker
    import tsb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          colors_pending,
    output int          colors_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] texels [0:65535];
    logic        filter_bilinear;
    logic        mirror_u;
    logic        mirror_v;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    out_item_t   color_queue [$];

    function automatic int unsigned clamp_size(input logic [8:0] s);
        if (s == 0) return 1;
        if (s > 256) return 256;
        return 32'(s);
    endfunction

    function automatic int unsigned fold_coord(input logic [31:0] raw, input logic mirror);
        if (!raw[31] && raw <= 32'h10000) return raw;
        if (mirror) return 32'h10000 - 32'(raw[15:0]);
        return 32'(raw[15:0]);
    endfunction

    function automatic logic [31:0] read_texel(input int unsigned row, input int unsigned col,
                                               input int unsigned w);
        int unsigned a;
        a = row * w + col;
        if (a >= 65536) return 32'h0;
        return texels[a];
    endfunction

    function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                          input int unsigned f);
        logic [31:0] r;
        int unsigned s;
        for (int i = 0; i < 4; i++) begin
            s = a[i*8 +: 8] * (32'h10000 - f) + b[i*8 +: 8] * f + 32'h8000;
            r[i*8 +: 8] = s[23:16];
        end
        return r;
    endfunction

    function automatic out_item_t sample_color(input logic [31:0] u, input logic [31:0] v);
        int unsigned w, h, px, py, fx, fy, left, bottom, right, top;
        logic [31:0] texel, lc, rc;
        out_item_t o;
        w = clamp_size(width_reg);
        h = clamp_size(height_reg);
        px = fold_coord(u, mirror_u) * (w - 1);
        py = fold_coord(v, mirror_v) * (h - 1);
        if (!filter_bilinear) begin
            texel = read_texel((py + 32'h8000) >> 16, (px + 32'h8000) >> 16, w);
        end else begin
            fx = px & 32'hFFFF;
            fy = py & 32'hFFFF;
            left = px >> 16;
            bottom = py >> 16;
            right = left + (fx != 0);
            top = bottom + (fy != 0);
            lc = blend(read_texel(bottom, left, w), read_texel(top, left, w), fy);
            rc = blend(read_texel(bottom, right, w), read_texel(top, right, w), fy);
            texel = blend(lc, rc, fx);
        end
        o.red = texel[7:0];
        o.green = texel[15:8];
        o.blue = texel[23:16];
        o.alpha = texel[31:24];
        return o;
    endfunction

    assign colors_pending = color_queue.size();

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            filter_bilinear <= 1'b0;
            mirror_u <= 1'b0;
            mirror_v <= 1'b0;
            width_reg <= 9'd1;
            height_reg <= 9'd1;
            color_queue.delete();
            fail_count <= 0;
            colors_checked <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_FILTER: filter_bilinear <= pwdata[0];
                    REG_WRAP_U: mirror_u <= pwdata[0];
                    REG_WRAP_V: mirror_v <= pwdata[0];
                    REG_WIDTH:  width_reg <= pwdata[8:0];
                    REG_HEIGHT: height_reg <= pwdata[8:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (color_queue.size() == 0) begin
                    $error("unexpected color transfer %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = color_queue.pop_front();
                    colors_checked <= colors_checked + 1;
                    if (want.red !== m_data.red)
                        $error("red: expected %0d, got %0d", want.red, m_data.red);
                    if (want.green !== m_data.green)
                        $error("green: expected %0d, got %0d", want.green, m_data.green);
                    if (want.blue !== m_data.blue)
                        $error("blue: expected %0d, got %0d", want.blue, m_data.blue);
                    if (want.alpha !== m_data.alpha)
                        $error("alpha: expected %0d, got %0d", want.alpha, m_data.alpha);
                    if (want !== m_data) fail_count <= fail_count + 1;
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.kind == KIND_WRITE)
                    texels[s_data.texel_index] = s_data.texel_rgba;
                else
                    color_queue.push_back(sample_color(s_data.coord_u, s_data.coord_v));
            end
        end
    end
endmodule

// ===== dv/texture_sampler_bilinear_tb.sv =====
// Testbench top for texture_sampler_bilinear: clock, reset, APB setup,
// texel fills and sample stimulus per phase. Depends on tsb_pkg and the checker.
module texture_sampler_bilinear_tb;
    import tsb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          colors_pending;
    int          colors_checked;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          items_sent = 0;

    texture_sampler_bilinear uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    texture_sampler_checker color_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .colors_pending(colors_pending),
        .colors_checked(colors_checked)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic write_texel(input logic [15:0] idx, input logic [31:0] rgba);
        in_item_t it;
        it = '0;
        it.kind = KIND_WRITE;
        it.texel_index = idx;
        it.texel_rgba = rgba;
        it.coord_u = $urandom;
        it.coord_v = $urandom;
        send_item(it);
    endtask

    task automatic sample_at(input logic [31:0] u, input logic [31:0] v);
        in_item_t it;
        it.kind = KIND_SAMPLE;
        it.texel_index = 16'($urandom);
        it.texel_rgba = $urandom;
        it.coord_u = u;
        it.coord_v = v;
        send_item(it);
    endtask

    task automatic apb_write(input logic [2:0] reg_code, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_code, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (colors_pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'h10000;
            2: return 32'h8000;
            3, 4, 5: return $urandom_range(32'h10000, 0);
            6: return $urandom;
            7: return -$urandom_range(32'h30000, 1);
            8: return 32'h10000 + $urandom_range(32'h30000, 1);
            default: return {$urandom_range(1, 0) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    function automatic int unsigned eff_dim(input logic [8:0] s);
        if (s == 0) return 1;
        if (s > 256) return 256;
        return 32'(s);
    endfunction

    task automatic run_phase(input int ph, input logic filt, input logic wu, input logic wv,
                             input logic [8:0] w, input logic [8:0] h, input int n_rand);
        int unsigned area;
        drain();
        send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 47 : 24) : 0;
        recv_idle_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 47 : 24) : 0;
        apb_write(REG_FILTER, {31'($urandom), filt});
        apb_write(REG_WRAP_U, {31'($urandom), wu});
        apb_write(REG_WRAP_V, {31'($urandom), wv});
        apb_write(REG_WIDTH, {23'($urandom), w});
        apb_write(REG_HEIGHT, {23'($urandom), h});
        area = eff_dim(w) * eff_dim(h);
        for (int unsigned i = 0; i < area; i++) write_texel(i[15:0], $urandom);
        if (ph == 5) hold_req++;
        for (int i = 0; i < n_rand; i++) begin
            if ($urandom_range(99) < 20) begin
                if ($urandom_range(1, 0)) write_texel(16'($urandom_range(area - 1, 0)), $urandom);
                else write_texel(16'($urandom), $urandom);
            end else begin
                sample_at(pick_coord(), pick_coord());
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners on a 2x2 bilinear texture with extreme texel values.
        apb_write(REG_FILTER, 32'h1);
        apb_write(REG_WIDTH, 32'd2);
        apb_write(REG_HEIGHT, 32'd2);
        write_texel(16'd0, 32'h00000000);
        write_texel(16'd1, 32'hFFFFFFFF);
        write_texel(16'd2, 32'hFF00FF00);
        write_texel(16'd3, 32'h00FF00FF);
        write_texel(16'hFFFF, 32'hFFFFFFFF);
        sample_at(32'h0, 32'h0);
        sample_at(32'h10000, 32'h10000);
        sample_at(32'h8000, 32'h8000);
        sample_at(32'h8000, 32'h0);
        sample_at(32'h0, 32'h8000);
        sample_at(32'h80000000, 32'h7FFFFFFF);
        sample_at(32'hFFFFFFFF, 32'h10001);
        sample_at(32'hFFFF0000, 32'h0001FFFF);
        sample_at(32'h00000001, 32'h0000FFFF);
        drain();
        apb_write(REG_WRAP_U, 32'h1);
        apb_write(REG_WRAP_V, 32'h1);
        sample_at(32'h80000000, 32'h7FFFFFFF);
        sample_at(32'hFFFFFFFF, 32'h10001);
        sample_at(32'hFFFF8000, 32'h00018000);
        drain();
        apb_write(REG_FILTER, 32'h0);
        sample_at(32'h7FFF, 32'h8000);
        sample_at(32'h8000, 32'h7FFF);
        sample_at(32'hFFFFFFFF, 32'h80000000);

        run_phase(0, 1'b1, 1'b0, 1'b0, 9'd2, 9'd2, 25);
        run_phase(1, 1'b0, 1'b0, 1'b0, 9'd1, 9'd1, 25);
        run_phase(2, 1'b1, 1'b1, 1'b1, 9'd256, 9'd1, 25);
        run_phase(3, 1'b1, 1'b0, 1'b1, 9'd1, 9'd256, 25);
        run_phase(4, 1'b0, 1'b1, 1'b0, 9'd5, 9'd7, 25);
        run_phase(5, 1'b1, 1'b1, 1'b0, 9'd0, 9'd3, 34);
        run_phase(6, 1'b1, 1'b0, 1'b1, 9'd511, 9'd1, 25);
        run_phase(7, 1'b0, 1'b1, 1'b1, 9'd9, 9'd8, 25);
        run_phase(8, 1'b1, 1'b1, 1'b1, 9'd1, 9'd300, 25);
        run_phase(9, 1'b1, 1'b0, 1'b0, 9'd9, 9'd4, 25);
        run_phase(10, 1'b0, 1'b0, 1'b1, 9'd3, 9'd0, 25);
        run_phase(11, 1'b1, 1'b1, 1'b0, 9'd13, 9'd11, 25);
        drain();

        $display("Sent %0d items and checked %0d colors over twelve register settings,",
                 items_sent, colors_checked);
        $display("with nearest and bilinear filtering, both wrap modes and sizes 1 to 256.");
        if (fail_count == 0 && colors_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/tsb_pkg.sv
rtl/tsb_ctrl.sv
rtl/tsb_datapath.sv
rtl/texture_sampler_bilinear.sv
dv/texture_sampler_checker.sv
dv/texture_sampler_bilinear_tb.sv
